### sv/dhs_pkg.sv
// shared types and constants of the drill hole sorter
package dhs_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int COORD_W         = 24;
	localparam int DIA_W           = 16;
	localparam int KEY_W           = DIA_W + 2 * COORD_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [DIA_W-1:0]          dia_t;
	typedef logic [KEY_W-1:0]          key_t;

	typedef struct packed {
		logic valid;
		logic gt;
		key_t key;
	} link_t;

	localparam logic [COORD_W-1:0] SIGN_FLIP = {1'b1, {(COORD_W-1){1'b0}}};

	function automatic key_t make_key(coord_t x, coord_t y, dia_t d);
		return {d, unsigned'(x) ^ SIGN_FLIP, unsigned'(y) ^ SIGN_FLIP};
	endfunction

endpackage

### sv/dhs_if.sv
// hole input and sorted output channel interfaces
interface dhs_in_if;
	import dhs_pkg::*;
	logic   valid;
	logic   ready;
	coord_t hole_x;
	coord_t hole_y;
	dia_t   hole_dia;
	logic   last_hole;

	modport source(output valid, hole_x, hole_y, hole_dia, last_hole, input ready);
	modport sink(input valid, hole_x, hole_y, hole_dia, last_hole, output ready);
endinterface

interface dhs_out_if;
	import dhs_pkg::*;
	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	dia_t   out_dia;
	logic   out_last;
	logic   overflowed;

	modport source(output valid, out_x, out_y, out_dia, out_last, overflowed, input ready);
	modport sink(input valid, out_x, out_y, out_dia, out_last, overflowed, output ready);
endinterface

### sv/dhs_cell.sv
// one sorting cell: holds a key, shifts right on insert and left on drain
module dhs_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          insert,
	input  logic          pop,
	input  dhs_pkg::key_t ins_key,
	input  dhs_pkg::link_t prv,
	input  dhs_pkg::link_t nxt,
	output dhs_pkg::link_t link
);
	import dhs_pkg::*;

	logic valid_q;
	key_t key_q;
	logic gt;

	assign gt   = valid_q && (key_q > ins_key);
	assign link = '{valid: valid_q, gt: gt, key: key_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= nxt.valid;
		end else if (insert) begin
			valid_q <= valid_q | prv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			key_q <= nxt.key;
		end else if (insert) begin
			if (prv.gt) begin
				key_q <= prv.key;
			end else if (gt || (!valid_q && prv.valid)) begin
				key_q <= ins_key;
			end
		end
	end

endmodule

### sv/drill_hole_sorter.sv
// drill hole sorter top level: insertion chain of cells with in-order drain
// Holes enter one per cycle into a chain of STORE_DEPTH cells kept sorted by
// diameter, then x, then y; equal keys keep arrival order. Every cell compares
// the new key in the same cycle and the chain shifts right by one. After the
// hole marked last, the chain drains from its head one beat per cycle while
// the receiver is ready, out_last on the final beat; no input is taken while
// it drains. A hole arriving at a full chain is dropped and overflowed is set
// on every beat of that run.
module drill_hole_sorter #(
	parameter int STORE_DEPTH = dhs_pkg::STORE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	dhs_in_if.sink    hole_in,
	dhs_out_if.source hole_out
);
	import dhs_pkg::*;

	logic             drain_q;
	logic             ovf_q;
	logic             in_beat;
	logic             out_beat;
	logic             full;
	logic             insert;
	key_t             ins_key;
	logic [STORE_DEPTH-1:0] vld;
	link_t            link [STORE_DEPTH];
	link_t            prv_l[STORE_DEPTH];
	link_t            nxt_l[STORE_DEPTH];

	assign hole_in.ready = !drain_q;
	assign in_beat       = hole_in.valid && hole_in.ready;
	assign out_beat      = hole_out.valid && hole_out.ready;
	assign full          = link[STORE_DEPTH-1].valid;
	assign insert        = in_beat && !full;
	assign ins_key       = make_key(hole_in.hole_x, hole_in.hole_y, hole_in.hole_dia);

	genvar i;
	generate
		for (i = 0; i < STORE_DEPTH; i++) begin : g_cell
			assign vld[i] = link[i].valid;
			if (i == 0) begin : g_head
				assign prv_l[i] = '{valid: 1'b1, gt: 1'b0, key: '0};
			end else begin : g_mid
				assign prv_l[i] = link[i-1];
			end
			if (i == STORE_DEPTH - 1) begin : g_tail
				assign nxt_l[i] = '{valid: 1'b0, gt: 1'b0, key: '0};
			end else begin : g_body
				assign nxt_l[i] = link[i+1];
			end
			dhs_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.insert (insert),
				.pop    (out_beat),
				.ins_key(ins_key),
				.prv    (prv_l[i]),
				.nxt    (nxt_l[i]),
				.link   (link[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (out_beat && hole_out.out_last) begin
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (in_beat) begin
			if (full) begin
				ovf_q <= 1'b1;
			end
			if (hole_in.last_hole) begin
				drain_q <= 1'b1;
			end
		end
	end

	assign hole_out.valid      = drain_q && link[0].valid;
	assign hole_out.out_x      = coord_t'(link[0].key[2*COORD_W-1:COORD_W] ^ SIGN_FLIP);
	assign hole_out.out_y      = coord_t'(link[0].key[COORD_W-1:0] ^ SIGN_FLIP);
	assign hole_out.out_dia    = link[0].key[KEY_W-1:2*COORD_W];
	assign hole_out.out_last   = !link[1].valid;
	assign hole_out.overflowed = ovf_q;

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(vld & (vld + 1'b1)) == '0)
		else $error("cell valid bits not packed at the head");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && hole_in.last_hole |=> hole_out.valid)
		else $error("last hole did not start the drain");

	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !hole_out.out_last |=> hole_out.valid)
		else $error("drain stopped before the final beat");

	generate
		for (i = 0; i + 1 < STORE_DEPTH; i++) begin : g_chk
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				link[i+1].valid |-> link[i].key <= link[i+1].key)
				else $error("chain out of order");
		end
	endgenerate

endmodule

### tb/sv/tb_drill_hole_sorter.sv
// self-checking testbench for the drill hole sorter against a sorted-store predictor
module tb_drill_hole_sorter;
	import dhs_pkg::*;

	localparam int DEPTH      = STORE_DEPTH_DEF;
	localparam int IDLE_PCT   = 34;
	localparam int HOLD_OFF   = 300;
	localparam int STALL_MAX  = 3000;
	localparam int DRAIN_WAIT = 20;

	typedef struct {
		coord_t x;
		coord_t y;
		dia_t   dia;
		logic   last;
	} hole_t;

	typedef struct {
		coord_t x;
		coord_t y;
		dia_t   dia;
		logic   last;
		logic   ovf;
	} sorted_hole_t;

	typedef struct packed {
		dia_t               dia;
		logic [COORD_W-1:0] x_key;
		logic [COORD_W-1:0] y_key;
	} sort_key_t;

	logic clk = 1'b0;
	logic arst_n;

	dhs_in_if  hole_in();
	dhs_out_if hole_out();

	drill_hole_sorter #(
		.STORE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.hole_in(hole_in),
		.hole_out(hole_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	hole_t        pending_holes[$];
	sorted_hole_t sorted_holes[$];
	sort_key_t    stored_keys[$];
	bit           set_overflow;
	int           error_count;
	int           holes_sent;
	int           beats_seen;
	int           hold_left;
	bit           hold_done;
	int           quiet_cycles;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// insert into the ordered store, dump the whole run on the last hole of a set
	task automatic sort_hole(coord_t x, coord_t y, dia_t d, logic last);
		sort_key_t    k;
		sorted_hole_t r;
		int           pos;
		k.dia   = d;
		k.x_key = x ^ SIGN_FLIP;
		k.y_key = y ^ SIGN_FLIP;
		if (stored_keys.size() >= DEPTH) begin
			set_overflow = 1'b1;
		end else begin
			pos = 0;
			while (pos < stored_keys.size() && stored_keys[pos] <= k)
				pos++;
			stored_keys.insert(pos, k);
		end
		if (last) begin
			for (int i = 0; i < stored_keys.size(); i++) begin
				r.x    = stored_keys[i].x_key ^ SIGN_FLIP;
				r.y    = stored_keys[i].y_key ^ SIGN_FLIP;
				r.dia  = stored_keys[i].dia;
				r.last = (i == stored_keys.size() - 1);
				r.ovf  = set_overflow;
				sorted_holes.push_back(r);
			end
			stored_keys.delete();
			set_overflow = 1'b0;
		end
	endtask

	task automatic queue_hole(coord_t x, coord_t y, dia_t d, logic last);
		hole_t h;
		h.x    = x;
		h.y    = y;
		h.dia  = d;
		h.last = last;
		pending_holes.push_back(h);
	endtask

	// hole driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_in.valid     <= 1'b0;
			hole_in.hole_x    <= '0;
			hole_in.hole_y    <= '0;
			hole_in.hole_dia  <= '0;
			hole_in.last_hole <= 1'b0;
			holes_sent        <= 0;
		end else begin
			if (hole_in.valid && hole_in.ready) begin
				sort_hole(hole_in.hole_x, hole_in.hole_y, hole_in.hole_dia, hole_in.last_hole);
				holes_sent <= holes_sent + 1;
			end
			if (!hole_in.valid || hole_in.ready) begin
				if (pending_holes.size() != 0 &&
				    ((holes_sent >= 150 && holes_sent < 240) ||
				     $urandom_range(99) >= IDLE_PCT)) begin
					hole_in.valid     <= 1'b1;
					hole_in.hole_x    <= pending_holes[0].x;
					hole_in.hole_y    <= pending_holes[0].y;
					hole_in.hole_dia  <= pending_holes[0].dia;
					hole_in.last_hole <= pending_holes[0].last;
					void'(pending_holes.pop_front());
				end else begin
					hole_in.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the chain stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && beats_seen >= 30) begin
			hold_left <= HOLD_OFF;
			hold_done <= 1'b1;
		end
	end

	// sorted beat monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_out.ready <= 1'b0;
			beats_seen     <= 0;
		end else begin
			if (hole_out.valid && hole_out.ready) begin
				beats_seen <= beats_seen + 1;
				if (sorted_holes.size() == 0) begin
					report_mismatch("beat with no hole pending", hole_out.out_dia, '0);
				end else begin
					if (hole_out.out_x !== sorted_holes[0].x)
						report_mismatch("out_x", hole_out.out_x, sorted_holes[0].x);
					if (hole_out.out_y !== sorted_holes[0].y)
						report_mismatch("out_y", hole_out.out_y, sorted_holes[0].y);
					if (hole_out.out_dia !== sorted_holes[0].dia)
						report_mismatch("out_dia", hole_out.out_dia, sorted_holes[0].dia);
					if (hole_out.out_last !== sorted_holes[0].last)
						report_mismatch("out_last", hole_out.out_last, sorted_holes[0].last);
					if (hole_out.overflowed !== sorted_holes[0].ovf)
						report_mismatch("overflowed", hole_out.overflowed, sorted_holes[0].ovf);
					void'(sorted_holes.pop_front());
				end
			end
			if (hold_left != 0)
				hole_out.ready <= 1'b0;
			else if (beats_seen >= 150 && beats_seen < 240)
				hole_out.ready <= 1'b1;
			else
				hole_out.ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((hole_in.valid && hole_in.ready) || (hole_out.valid && hole_out.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		hole_t       prev;
		logic [31:0] rnd;
		int          set_size;
		int          set_idx;
		int          rand_holes;
		coord_t      x;
		coord_t      y;
		dia_t        d;

		arst_n = 1'b0;

		// extremes of every field, sign order of coordinates
		queue_hole(24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 1'b0);
		queue_hole(-24'sh800000, -24'sh800000, 16'h0000, 1'b0);
		queue_hole(24'sh000000, 24'sh000000, 16'h0000, 1'b0);
		queue_hole(-24'sh000001, -24'sh000001, 16'h0000, 1'b0);
		queue_hole(24'sd5, -24'sd3, 16'd100, 1'b0);
		queue_hole(24'sd5, -24'sd4, 16'd100, 1'b0);
		queue_hole(-24'sd5, 24'sd7, 16'd100, 1'b0);
		queue_hole(-24'sh800000, 24'sh7FFFFF, 16'hFFFF, 1'b0);
		queue_hole(24'sh7FFFFF, -24'sh800000, 16'h0001, 1'b1);
		// single-hole set
		queue_hole(-24'sh000001, 24'sh000000, 16'hFFFF, 1'b1);
		// equal keys
		queue_hole(24'sd100, 24'sd200, 16'd300, 1'b0);
		queue_hole(24'sd100, 24'sd200, 16'd300, 1'b0);
		queue_hole(24'sd100, 24'sd200, 16'd300, 1'b0);
		queue_hole(24'sd100, 24'sd200, 16'd299, 1'b0);
		queue_hole(24'sd100, 24'sd200, 16'd300, 1'b1);
		// alternating bit patterns
		queue_hole(24'sh555555, 24'shAAAAAA, 16'hAAAA, 1'b0);
		queue_hole(24'shAAAAAA, 24'sh555555, 16'h5555, 1'b0);
		queue_hole(24'sh000000, 24'sh000000, 16'hAAAA, 1'b1);

		// random sets, mostly small; full store, last hole dropped, deeper overflow
		prev       = '{x: '0, y: '0, dia: '0, last: 1'b0};
		rand_holes = 0;
		set_idx    = 0;
		while (rand_holes < 330) begin
			case (set_idx)
				4:       set_size = DEPTH;
				9:       set_size = DEPTH + 1;
				14:      set_size = DEPTH + 6;
				default: set_size = $urandom_range(12, 1);
			endcase
			for (int i = 0; i < set_size; i++) begin
				rnd = $urandom();
				x = ($urandom_range(3) != 0) ? coord_t'(rnd[23:0]) : prev.x;
				rnd = $urandom();
				y = ($urandom_range(3) != 0) ? coord_t'(rnd[23:0]) : prev.y;
				rnd = $urandom();
				case ($urandom_range(2))
					0:       d = rnd[15:0];
					1:       d = dia_t'($urandom_range(3));
					default: d = prev.dia;
				endcase
				queue_hole(x, y, d, i == set_size - 1);
				prev = pending_holes[$];
			end
			rand_holes += set_size;
			set_idx++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_holes.size() == 0 && !hole_in.valid);
		wait (sorted_holes.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sorted_holes.size() != 0)
			report_mismatch("holes never emitted", sorted_holes.size(), '0);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
sv/dhs_pkg.sv
sv/dhs_if.sv
sv/dhs_cell.sv
sv/drill_hole_sorter.sv
tb/sv/tb_drill_hole_sorter.sv
